### hw/rtl/ldm_pkg.sv
// Shared constants and types of the 3x3 local maximum detector.
package ldm_pkg;

    localparam int ROW_BITS    = 10;
    localparam int OUT_BITS    = 10;
    localparam int CFG_BITS    = 11;
    localparam int MAX_ROWS    = 1024;
    localparam int ADDR_BITS   = 3;
    localparam int NUM_CAND    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [NUM_CAND-1:0] cand_mask_t;
    typedef logic [CFG_BITS-1:0] cfg_t;

endpackage

### hw/rtl/ldm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ldm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ldm_queue.sv
// Small FIFO between the pixel front end and the report back end.
module ldm_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               push_data,
    input  logic                           pop,
    output logic [WIDTH-1:0]               pop_data,
    output logic                           not_empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = data_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### hw/rtl/ldm_front.sv
// Front end: pixel position, line stores, 3x3 window and maximum decisions.
module ldm_front #(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             restart,
    input  ldm_pkg::row_t                    last_row,
    input  logic [$clog2(MAX_COLS)-1:0]      last_col,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [15:0]                      pixel_value,
    input  logic [ldm_pkg::QCOUNT_BITS-1:0]  q_count,
    output logic                             push,
    output ldm_pkg::cand_mask_t              push_mask,
    output ldm_pkg::row_t                    push_row,
    output logic [$clog2(MAX_COLS)-1:0]      push_col
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int PB = PIXEL_BITS;

    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic r_last;
        logic c_last;
    } pos_flags_t;

    localparam int CEN_ROW [ldm_pkg::NUM_CAND] = '{1, 1, 2, 2};
    localparam int CEN_COL [ldm_pkg::NUM_CAND] = '{1, 2, 1, 2};

    logic                accept;
    logic [PB-1:0]       px;
    ldm_pkg::row_t       row_pos_reg, row_pos_next;
    logic [CW-1:0]       col_pos_reg, col_pos_next;
    pos_flags_t          flags;

    logic                s1_valid_reg;
    logic [PB-1:0]       s1_px_reg;
    ldm_pkg::row_t       s1_row_reg;
    logic [CW-1:0]       s1_col_reg;
    pos_flags_t          s1_flags_reg;
    logic                fwd_hit_reg;
    logic [2*PB-1:0]     fwd_data_reg;

    logic [2*PB-1:0]     ram_rdata;
    logic [2*PB-1:0]     pair;
    logic [PB-1:0]       top_px;
    logic [PB-1:0]       mid_px;
    logic [2*PB-1:0]     ram_wdata;

    logic [PB-1:0]       window_reg [3][3];
    logic                s2_valid_reg;
    ldm_pkg::row_t       s2_row_reg;
    logic [CW-1:0]       s2_col_reg;
    pos_flags_t          s2_flags_reg;

    logic [PB-1:0]       centre [ldm_pkg::NUM_CAND];
    logic [2:0]          row_mask [ldm_pkg::NUM_CAND];
    logic [2:0]          col_mask [ldm_pkg::NUM_CAND];
    ldm_pkg::cand_mask_t cand_en;
    ldm_pkg::cand_mask_t cand_viol;
    logic [ldm_pkg::QCOUNT_BITS-1:0] credit_used;

    assign credit_used = q_count + ldm_pkg::QCOUNT_BITS'(s1_valid_reg)
                       + ldm_pkg::QCOUNT_BITS'(s2_valid_reg);
    assign in_ready    = (credit_used < ldm_pkg::QCOUNT_BITS'(ldm_pkg::QUEUE_DEPTH));
    assign accept      = in_valid && in_ready;
    assign px          = PB'(pixel_value);

    assign flags.r_ge1  = (row_pos_reg != '0);
    assign flags.r_ge2  = (row_pos_reg > ldm_pkg::row_t'(1));
    assign flags.c_ge1  = (col_pos_reg != '0);
    assign flags.c_ge2  = (col_pos_reg > CW'(1));
    assign flags.r_last = (row_pos_reg == last_row);
    assign flags.c_last = (col_pos_reg == last_col);

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (restart)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (accept)
        begin
            if (flags.c_last)
            begin
                col_pos_next = '0;
                row_pos_next = flags.r_last ? '0 : row_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    // Line store entry holds {row r-2, row r-1} of one column.
    ldm_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (ram_rdata)
    );

    assign pair      = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign top_px    = pair[2*PB-1:PB];
    assign mid_px    = pair[PB-1:0];
    assign ram_wdata = {mid_px, s1_px_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    window_reg[a][b] <= '0;
                end
            end
        end
        else
        begin
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            // Bypass a write that lands on the column read in the same cycle.
            fwd_hit_reg  <= accept && s1_valid_reg && (col_pos_reg == s1_col_reg);
            if (s1_valid_reg)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    window_reg[a][0] <= window_reg[a][1];
                    window_reg[a][1] <= window_reg[a][2];
                end
                window_reg[0][2] <= top_px;
                window_reg[1][2] <= mid_px;
                window_reg[2][2] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= px;
            s1_row_reg   <= row_pos_reg;
            s1_col_reg   <= col_pos_reg;
            s1_flags_reg <= flags;
        end
        fwd_data_reg <= ram_wdata;
        if (s1_valid_reg)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // Candidates in raster order: (r-1,c-1), (r-1,c), (r,c-1), (r,c).
    always_comb
    begin
        centre[0] = window_reg[1][1];
        centre[1] = window_reg[1][2];
        centre[2] = window_reg[2][1];
        centre[3] = window_reg[2][2];

        row_mask[0] = {1'b1, 1'b1, s2_flags_reg.r_ge2};
        row_mask[1] = {1'b1, 1'b1, s2_flags_reg.r_ge2};
        row_mask[2] = {1'b1, s2_flags_reg.r_ge1, 1'b0};
        row_mask[3] = {1'b1, s2_flags_reg.r_ge1, 1'b0};
        col_mask[0] = {1'b1, 1'b1, s2_flags_reg.c_ge2};
        col_mask[1] = {1'b1, s2_flags_reg.c_ge1, 1'b0};
        col_mask[2] = {1'b1, 1'b1, s2_flags_reg.c_ge2};
        col_mask[3] = {1'b1, s2_flags_reg.c_ge1, 1'b0};

        cand_en[0] = s2_flags_reg.r_ge1 && s2_flags_reg.c_ge1;
        cand_en[1] = s2_flags_reg.r_ge1 && s2_flags_reg.c_last;
        cand_en[2] = s2_flags_reg.r_last && s2_flags_reg.c_ge1;
        cand_en[3] = s2_flags_reg.r_last && s2_flags_reg.c_last;

        cand_viol = '0;
        for (int k = 0; k < ldm_pkg::NUM_CAND; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    if (row_mask[k][a] && col_mask[k][b]
                        && !(a == CEN_ROW[k] && b == CEN_COL[k])
                        && (window_reg[a][b] > centre[k]))
                    begin
                        cand_viol[k] = 1'b1;
                    end
                end
            end
        end
    end

    assign push_mask = cand_en & ~cand_viol;
    assign push      = s2_valid_reg && (push_mask != '0);
    assign push_row  = s2_row_reg;
    assign push_col  = s2_col_reg;

endmodule

### hw/rtl/ldm_back.sv
// Back end: expand one decision entry into reports, one per cycle while out_ready is high.
module ldm_back #(
    parameter int COL_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  ldm_pkg::cand_mask_t       q_mask,
    input  ldm_pkg::row_t             q_row,
    input  logic [COL_BITS-1:0]       q_col,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ldm_pkg::OUT_BITS-1:0] max_row,
    output logic [ldm_pkg::OUT_BITS-1:0] max_col,
    output logic                      run_last
);

    logic                cur_valid_reg;
    ldm_pkg::cand_mask_t cur_mask_reg;
    ldm_pkg::row_t       cur_row_reg;
    logic [COL_BITS-1:0] cur_col_reg;

    ldm_pkg::cand_mask_t low_bit;
    ldm_pkg::cand_mask_t rest;
    logic                sel_this_row;
    logic                sel_this_col;
    logic                take;
    logic                finish;

    assign low_bit = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign rest    = cur_mask_reg & ~low_bit;

    always_comb
    begin
        case (low_bit)
            4'b0010: {sel_this_row, sel_this_col} = 2'b01;
            4'b0100: {sel_this_row, sel_this_col} = 2'b10;
            4'b1000: {sel_this_row, sel_this_col} = 2'b11;
            default: {sel_this_row, sel_this_col} = 2'b00;
        endcase
    end

    assign take   = cur_valid_reg && out_ready;
    assign finish = take && (rest == '0);
    assign pop    = q_valid && (!cur_valid_reg || finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (finish)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_mask_reg <= q_mask;
            cur_row_reg  <= q_row;
            cur_col_reg  <= q_col;
        end
        else if (take)
        begin
            cur_mask_reg <= rest;
        end
    end

    assign out_valid = cur_valid_reg;
    assign max_row   = ldm_pkg::OUT_BITS'(sel_this_row ? cur_row_reg : cur_row_reg - 1'b1);
    assign max_col   = ldm_pkg::OUT_BITS'(sel_this_col ? cur_col_reg : cur_col_reg - 1'b1);
    assign run_last  = (rest == '0);

endmodule

### hw/rtl/local_maximum_3x3_detector.sv
// Top level of the 3x3 local maximum detector: register port, front, queue, back.
// Throughput: one pixel per cycle while queue credit is free; a pixel that decides
// several maxima (row end, last row) gives up to four reports, one per cycle while
// out_ready is high; its entry is buffered in a four-entry queue. A pixel's
// path: line store read, window shift, queue, back end; waiting reports delay it.
// Reset: position, queue and window cleared, both counts read 1; line stores are
// not cleared and need no clearing pass.
module local_maximum_3x3_detector #(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ldm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [15:0]                    pixel_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [9:0]                     max_row,
    output logic [9:0]                     max_col,
    output logic                           run_last
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int QW = ldm_pkg::NUM_CAND + ldm_pkg::ROW_BITS + CW;

    ldm_pkg::cfg_t       row_count_reg;
    ldm_pkg::cfg_t       col_count_reg;
    logic                cfg_write;
    ldm_pkg::row_t       last_row;
    logic [CW-1:0]       last_col;

    logic                push;
    ldm_pkg::cand_mask_t push_mask;
    ldm_pkg::row_t       push_row;
    logic [CW-1:0]       push_col;
    logic                pop;
    logic [QW-1:0]       q_data;
    logic                q_valid;
    logic [ldm_pkg::QCOUNT_BITS-1:0] q_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ldm_pkg::cfg_t'(1);
            col_count_reg <= ldm_pkg::cfg_t'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                ldm_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[ldm_pkg::CFG_BITS-1:0];
                ldm_pkg::REG_COL_COUNT: col_count_reg <= pwdata[ldm_pkg::CFG_BITS-1:0];
                default:                row_count_reg <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ldm_pkg::REG_ROW_COUNT: prdata = 32'(row_count_reg);
            ldm_pkg::REG_COL_COUNT: prdata = 32'(col_count_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp the counts to the supported range.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(row_count_reg) > ldm_pkg::MAX_ROWS)
        begin
            last_row = ldm_pkg::ROW_BITS'(ldm_pkg::MAX_ROWS - 1);
        end
        else
        begin
            last_row = ldm_pkg::ROW_BITS'(row_count_reg - 1'b1);
        end

        if (col_count_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(col_count_reg) > MAX_COLS)
        begin
            last_col = CW'(MAX_COLS - 1);
        end
        else
        begin
            last_col = CW'(col_count_reg - 1'b1);
        end
    end

    ldm_front #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_write),
        .last_row    (last_row),
        .last_col    (last_col),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .q_count     (q_count),
        .push        (push),
        .push_mask   (push_mask),
        .push_row    (push_row),
        .push_col    (push_col)
    );

    ldm_queue #(
        .WIDTH (QW),
        .DEPTH (ldm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_mask, push_row, push_col}),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .count     (q_count)
    );

    ldm_back #(
        .COL_BITS (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_mask    (q_data[QW-1 -: ldm_pkg::NUM_CAND]),
        .q_row     (q_data[CW +: ldm_pkg::ROW_BITS]),
        .q_col     (q_data[CW-1:0]),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_row   (max_row),
        .max_col   (max_col),
        .run_last  (run_last)
    );

endmodule

### tb/sv/tb_local_maximum_3x3_detector.sv
// Self-checking testbench of the 3x3 local maximum detector with a built-in peak predictor.
module tb_local_maximum_3x3_detector;

    localparam int          GRID_LIMIT    = 1024;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          RANDOM_ITEMS  = 280;
    localparam int          REPORT_LIMIT  = 10;
    localparam int unsigned RUN_LIMIT     = 1000000;

    typedef enum int {PIX_FULL, PIX_FLAT, PIX_EDGE} pix_mode_t;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       run_last;
    } peak_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [ldm_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [15:0] pixel_value = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [9:0]  max_row;
    logic [9:0]  max_col;
    logic        run_last;

    logic [15:0] pixel_queue[$];
    peak_t       maxima_due[$];

    logic [15:0] older_row_store[GRID_LIMIT];
    logic [15:0] newer_row_store[GRID_LIMIT];
    logic [15:0] window[3][3];
    int          pos_row;
    int          pos_col;
    ldm_pkg::cfg_t rows_reg;
    ldm_pkg::cfg_t cols_reg;

    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    logic        hold_go    = 1'b0;
    logic        hold_done  = 1'b0;
    logic        idle_on    = 1'b1;
    int          fault_count  = 0;
    int          report_count = 0;

    local_maximum_3x3_detector i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .max_row     (max_row),
        .max_col     (max_col),
        .run_last    (run_last)
    );

    function automatic int clamp_count(input ldm_pkg::cfg_t value);
        if (value == 0)
            return 1;
        if (value > GRID_LIMIT)
            return GRID_LIMIT;
        return int'(value);
    endfunction

    function automatic bit is_peak(input int i, input int j, input int r, input int c,
                                   input int rows, input int cols);
        logic [15:0] centre;
        int          ni;
        int          nj;
        int          wr;
        int          wc;
        centre = window[i - r + 2][j - c + 2];
        for (int a = -1; a <= 1; a++)
        begin
            for (int b = -1; b <= 1; b++)
            begin
                ni = i + a;
                nj = j + b;
                wr = ni - r + 2;
                wc = nj - c + 2;
                if ((a != 0 || b != 0) && ni >= 0 && ni < rows && nj >= 0 && nj < cols
                    && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
                begin
                    if (window[wr][wc] > centre)
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_maxima(input logic [15:0] px);
        int          rows;
        int          cols;
        int          r;
        int          c;
        int          i;
        int          j;
        int          found_n;
        peak_t       found[ldm_pkg::NUM_CAND];
        logic [15:0] top;
        logic [15:0] mid;
        rows = clamp_count(rows_reg);
        cols = clamp_count(cols_reg);
        if (pos_row >= rows)
            pos_row = 0;
        if (pos_col >= cols)
            pos_col = 0;
        r = pos_row;
        c = pos_col;
        top = older_row_store[c];
        mid = newer_row_store[c];
        older_row_store[c] = mid;
        newer_row_store[c] = px;
        for (int k = 0; k < 3; k++)
        begin
            window[k][0] = window[k][1];
            window[k][1] = window[k][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = px;
        found_n = 0;
        for (int di = 0; di < 2; di++)
        begin
            i = r - 1 + di;
            if ((di == 0) ? (r >= 1) : (r == rows - 1))
            begin
                for (int dj = 0; dj < 2; dj++)
                begin
                    j = c - 1 + dj;
                    if (((dj == 0) ? (c >= 1) : (c == cols - 1))
                        && is_peak(i, j, r, c, rows, cols))
                    begin
                        found[found_n].row      = i[9:0];
                        found[found_n].col      = j[9:0];
                        found[found_n].run_last = 1'b0;
                        found_n++;
                    end
                end
            end
        end
        for (int k = 0; k < found_n; k++)
        begin
            if (k == found_n - 1)
                found[k].run_last = 1'b1;
            maxima_due.push_back(found[k]);
        end
        if (pos_col + 1 >= cols)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= rows) ? 0 : pos_row + 1;
        end
        else
            pos_col++;
    endfunction

    function automatic logic [15:0] draw_pixel(input pix_mode_t mode);
        case (mode)
            PIX_FLAT: return 16'($urandom_range(0, 2));
            PIX_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
            default:  return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic ldm_pkg::cfg_t draw_count(input int top);
        case ($urandom_range(0, 11))
            0:       return ldm_pkg::cfg_t'(0);
            1:       return ldm_pkg::cfg_t'(1);
            default: return ldm_pkg::cfg_t'($urandom_range(1, top));
        endcase
    endfunction

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_idx == ldm_pkg::REG_ROW_COUNT)
            rows_reg = value[ldm_pkg::CFG_BITS-1:0];
        else
            cols_reg = value[ldm_pkg::CFG_BITS-1:0];
        pos_row = 0;
        pos_col = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixels(input int count, input pix_mode_t mode);
        @(negedge clk);
        for (int k = 0; k < count; k++)
            pixel_queue.push_back(draw_pixel(mode));
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || maxima_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic log_mismatch(input peak_t want, input bit none_due);
        fault_count++;
        if (report_count < REPORT_LIMIT)
        begin
            report_count++;
            if (none_due)
                $display("unexpected item: row %0d col %0d last %0b",
                         max_row, max_col, run_last);
            else
                $display("mismatch: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                         want.row, want.col, want.run_last, max_row, max_col, run_last);
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel_value <= '0;
            gap_left    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_maxima(pixel_value);
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pixel_queue.size() != 0)
                begin
                    in_valid    <= 1'b1;
                    pixel_value <= pixel_queue.pop_front();
                    gap_left    <= (idle_on && hold_left == 0) ? $urandom_range(0, 9) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned wait_n;
        peak_t       want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            wait_n = stall_left;
            if (out_valid && out_ready)
            begin
                if (maxima_due.size() == 0)
                    log_mismatch('0, 1'b1);
                else
                begin
                    want = maxima_due.pop_front();
                    if (want.row != max_row || want.col != max_col
                        || want.run_last != run_last)
                        log_mismatch(want, 1'b0);
                end
                wait_n = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (wait_n != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= wait_n - 1;
            end
            else
            begin
                out_ready  <= (hold_left == 0);
                stall_left <= 0;
            end
        end
    end

    initial
    begin
        int            sent;
        int            phase;
        int            frame;
        int            count;
        ldm_pkg::cfg_t rows_pick;
        ldm_pkg::cfg_t cols_pick;
        bit            wide;
        pix_mode_t     mode;

        rows_reg = ldm_pkg::cfg_t'(1);
        cols_reg = ldm_pkg::cfg_t'(1);
        pos_row  = 0;
        pos_col  = 0;
        for (int k = 0; k < GRID_LIMIT; k++)
        begin
            older_row_store[k] = '0;
            newer_row_store[k] = '0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                window[a][b] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // plateau: every pixel ties, the last one decides four; then a mixed 3x3 frame
        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd3);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'd3);
        @(negedge clk);
        for (int k = 0; k < 9; k++)
            pixel_queue.push_back(16'h8000);
        foreach (pixel_queue[k])
            ;
        pixel_queue.push_back(16'h0000);
        pixel_queue.push_back(16'hFFFF);
        pixel_queue.push_back(16'h0000);
        pixel_queue.push_back(16'h0001);
        pixel_queue.push_back(16'h0000);
        pixel_queue.push_back(16'h0002);
        pixel_queue.push_back(16'hFFFF);
        pixel_queue.push_back(16'h0001);
        pixel_queue.push_back(16'hFFFF);
        settle();

        // zero counts act as one, upper data bits are dropped
        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd0);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'hFFFF_F800);
        @(negedge clk);
        pixel_queue.push_back(16'hFFFF);
        pixel_queue.push_back(16'h0000);
        settle();

        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd1);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'd5);
        @(negedge clk);
        pixel_queue.push_back(16'd5);
        pixel_queue.push_back(16'd5);
        pixel_queue.push_back(16'd3);
        pixel_queue.push_back(16'd7);
        pixel_queue.push_back(16'd7);
        settle();

        // largest counts, partial frames only
        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd2047);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'd2047);
        queue_pixels(48, PIX_FULL);
        settle();
        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd1);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'd1024);
        queue_pixels(48, PIX_EDGE);
        settle();
        write_reg(ldm_pkg::REG_ROW_COUNT, 32'd1024);
        write_reg(ldm_pkg::REG_COL_COUNT, 32'd2);
        queue_pixels(48, PIX_FLAT);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wide      = ($urandom_range(0, 9) == 0);
            rows_pick = draw_count(6);
            cols_pick = wide ? ldm_pkg::cfg_t'($urandom_range(9, 2047)) : draw_count(8);
            mode      = pix_mode_t'($urandom_range(0, 2));
            frame     = clamp_count(rows_pick) * clamp_count(cols_pick);
            count     = frame * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0)
                count += $urandom_range(1, frame);
            if (wide || count > 120)
                count = $urandom_range(24, 72);
            if (phase == 1)
            begin
                rows_pick = ldm_pkg::cfg_t'(4);
                cols_pick = ldm_pkg::cfg_t'(8);
                mode      = PIX_FLAT;
                count     = 96;
            end
            write_reg(ldm_pkg::REG_ROW_COUNT, 32'(rows_pick));
            write_reg(ldm_pkg::REG_COL_COUNT, 32'(cols_pick));
            idle_on <= ($urandom_range(0, 3) != 0);
            if (phase == 1)
                hold_go <= 1'b1;
            queue_pixels(count, mode);
            sent += count;
            phase++;
            settle();
        end

        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
